// ===== hw/rtl/jshm_pkg.sv =====
// Shared types and constants for the jitter sample health monitor.
// No dependencies; imported by every module of the block.
package jshm_pkg;

  localparam int unsigned TsW    = 64;
  localparam int unsigned CntW   = 16;
  localparam int unsigned SymW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  localparam logic [CntW-1:0] RepeatCutoffRst = 16'd32;
  localparam logic [CntW-1:0] WindowSizeRst   = 16'd512;
  localparam logic [CntW-1:0] WindowCutoffRst = 16'd496;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRepeatCutoff = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindowSize   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindowCutoff = 2'd2;

  // How the front classified a sample
  typedef enum logic [1:0] {
    KIND_NO_PRIOR = 2'd0,
    KIND_STUCK    = 2'd1,
    KIND_TEST     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED = 2'd0,
    VERDICT_NO_PRIOR = 2'd1,
    VERDICT_STUCK    = 2'd2,
    VERDICT_FAILED   = 2'd3
  } verdict_e;

  typedef struct packed {
    kind_e           kind;
    logic [TsW-1:0]  d1;
    logic [TsW-1:0]  d2;
    logic [TsW-1:0]  d3;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0] repeat_cutoff;
    logic [CntW-1:0] window_size;
    logic [CntW-1:0] window_cutoff;
  } cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v != CountMax) ? v + 1'b1 : v;
  endfunction

endpackage

// ===== hw/rtl/jshm_front.sv =====
// Front part: takes timestamps, forms the three differences over two stages
// and classifies each sample. Depends on jshm_pkg.
module jshm_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ts_valid_i,
  output logic                     ts_ready_o,
  input  logic [jshm_pkg::TsW-1:0] ts_i,
  input  logic                     full_i,
  output logic                     push_o,
  output jshm_pkg::entry_t         entry_o
);
  import jshm_pkg::*;

  logic           s1_v_q, s2_v_q;
  logic           s1_use_q, s2_use_q;
  logic [TsW-1:0] s1_d1_q, s2_d1_q, s2_d2_q;
  logic [TsW-1:0] prev_ts_q, prior_delta_q, prior_sd_q;

  logic           s1_ready, s2_ready, take, mv12;
  logic [TsW-1:0] d3;

  assign s2_ready   = !s2_v_q || !full_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign ts_ready_o = s1_ready;
  // zero timestamps complete the handshake and are dropped
  assign take       = ts_valid_i && s1_ready && (ts_i != '0);
  assign mv12       = s1_v_q && s2_ready;
  assign push_o     = s2_v_q && !full_i;

  assign d3 = s2_use_q ? (s2_d2_q - prior_sd_q) : '0;

  always_comb begin
    entry_o.d1 = s2_d1_q;
    entry_o.d2 = s2_d2_q;
    entry_o.d3 = d3;
    if (!s2_use_q) begin
      entry_o.kind = KIND_NO_PRIOR;
    end else if (s2_d1_q == '0 || s2_d2_q == '0 || d3 == '0) begin
      entry_o.kind = KIND_STUCK;
    end else begin
      entry_o.kind = KIND_TEST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      prev_ts_q     <= '0;
      prior_delta_q <= '0;
      prior_sd_q    <= '0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= take;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (take) begin
        prev_ts_q <= ts_i;
      end
      if (mv12 && s1_use_q) begin
        prior_delta_q <= s1_d1_q;
      end
      if (push_o && s2_use_q) begin
        prior_sd_q <= s2_d2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_d1_q  <= ts_i - prev_ts_q;
      s1_use_q <= (prev_ts_q != '0) && (ts_i > prev_ts_q);
    end
    if (mv12) begin
      s2_use_q <= s1_use_q;
      if (s1_use_q) begin
        s2_d1_q <= s1_d1_q;
        s2_d2_q <= prior_delta_q - s1_d1_q;
      end else begin
        s2_d1_q <= '0;
        s2_d2_q <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/jshm_fifo.sv =====
// Two-entry queue between front and back parts.
// Depends on jshm_pkg for the entry type.
module jshm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jshm_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output jshm_pkg::entry_t rdata_o,
  output logic             empty_o
);
  import jshm_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/jshm_back.sv =====
// Back part: repetition count and adaptive proportion tests, failure
// counter and the output register. Depends on jshm_pkg.
module jshm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jshm_pkg::cfg_t            cfg_i,
  input  logic                      empty_i,
  input  jshm_pkg::entry_t          entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                out_user_o,
  output logic [207:0]              out_data_o
);
  import jshm_pkg::*;

  logic             any_acc_q, any_acc_d;
  logic [TsW-1:0]   rep_val_q, rep_val_d;
  logic [CntW-1:0]  rep_run_q, rep_run_d;
  logic [SymW-1:0]  win_sym_q, win_sym_d;
  logic [CntW-1:0]  win_m_q, win_m_d;
  logic [CntW-1:0]  win_p_q, win_p_d;
  logic [CntW-1:0]  fail_q, fail_d;
  logic             out_v_q;
  logic [2:0]       out_user_q;
  logic [207:0]     out_data_q;

  logic [SymW-1:0]  sym;
  logic [CntW-1:0]  run_n, m_n, p_n, fail_1;
  logic             f_rep, f_win, pass;
  verdict_e         verdict;

  assign pop_o       = !empty_i && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

  assign sym = entry_i.d1[SymW-1:0] ^ entry_i.d2[SymW-1:0] ^ entry_i.d3[SymW-1:0];

  // Test arithmetic for a sample after the first accepted one
  always_comb begin
    run_n  = (entry_i.d1 == rep_val_q) ? sat_inc(rep_run_q) : 16'd1;
    f_rep  = (run_n >= cfg_i.repeat_cutoff);
    if (win_p_q == '0) begin
      m_n = 16'd1;
      p_n = 16'd1;
    end else begin
      m_n = (sym == win_sym_q) ? sat_inc(win_m_q) : win_m_q;
      p_n = sat_inc(win_p_q);
    end
    f_win  = (p_n >= cfg_i.window_size) && (m_n >= cfg_i.window_cutoff);
    fail_1 = f_rep ? sat_inc(fail_q) : fail_q;
  end

  always_comb begin
    any_acc_d = any_acc_q;
    rep_val_d = rep_val_q;
    rep_run_d = rep_run_q;
    win_sym_d = win_sym_q;
    win_m_d   = win_m_q;
    win_p_d   = win_p_q;
    fail_d    = fail_q;
    pass      = 1'b0;
    verdict   = VERDICT_NO_PRIOR;
    case (entry_i.kind)
      KIND_NO_PRIOR: verdict = VERDICT_NO_PRIOR;
      KIND_STUCK:    verdict = VERDICT_STUCK;
      KIND_TEST: begin
        if (!any_acc_q) begin
          rep_val_d = entry_i.d1;
          rep_run_d = 16'd1;
          win_sym_d = sym;
          win_m_d   = 16'd1;
          win_p_d   = 16'd1;
          pass      = 1'b1;
        end else begin
          rep_val_d = entry_i.d1;
          rep_run_d = run_n;
          if (win_p_q == '0) begin
            win_sym_d = sym;
          end
          if (p_n >= cfg_i.window_size) begin
            win_p_d = '0;
            win_m_d = '0;
          end else begin
            win_p_d = p_n;
            win_m_d = m_n;
          end
          fail_d = f_win ? sat_inc(fail_1) : fail_1;
          pass   = (fail_d == '0);
        end
        any_acc_d = any_acc_q | pass;
        verdict   = pass ? VERDICT_ACCEPTED : VERDICT_FAILED;
      end
      default: verdict = VERDICT_NO_PRIOR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_acc_q <= 1'b0;
      rep_val_q <= '0;
      rep_run_q <= '0;
      win_sym_q <= '0;
      win_m_q   <= '0;
      win_p_q   <= '0;
      fail_q    <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        any_acc_q <= any_acc_d;
        rep_val_q <= rep_val_d;
        rep_run_q <= rep_run_d;
        win_sym_q <= win_sym_d;
        win_m_q   <= win_m_d;
        win_p_q   <= win_p_d;
        fail_q    <= fail_d;
        out_v_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_user_q <= {verdict, (verdict == VERDICT_ACCEPTED)};
      out_data_q <= {fail_d, entry_i.d3, entry_i.d2, entry_i.d1};
    end
  end

endmodule

// ===== hw/rtl/jitter_sample_health_monitor_unit.sv =====
// An accepted timestamp passes the two difference stages, the queue and the
// output register before its result is valid; zero timestamps give none.
// Throughput: one timestamp per cycle sustained; the input stalls only when
// the two-entry queue is full because the output side holds back.
// Reset (rst_ni low, async): history, test state, failure count and queue
// clear; configuration returns to cutoff 32, window 512, window cutoff 496.
module jitter_sample_health_monitor_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // timestamp stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [63:0]   s_axis_tdata_i,   // [63:0] timestamp
  // result stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [207:0]  m_axis_tdata_o,   // [63:0] delta, [127:64] second_diff,
                                          // [191:128] third_diff,
                                          // [207:192] failure_count
  output logic [2:0]    m_axis_tuser_o,   // [0] accepted, [2:1] verdict
  // configuration write channel
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  import jshm_pkg::*;

  cfg_t   cfg_q;
  entry_t push_entry, pop_entry;
  logic   push, pop, full, empty;

  // Config writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_cutoff <= RepeatCutoffRst;
      cfg_q.window_size   <= WindowSizeRst;
      cfg_q.window_cutoff <= WindowCutoffRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRepeatCutoff: cfg_q.repeat_cutoff <= cfg_data_i;
        RegWindowSize:   cfg_q.window_size   <= cfg_data_i;
        RegWindowCutoff: cfg_q.window_cutoff <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: differences and stuck classification, in step with the input
  jshm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ts_valid_i (s_axis_tvalid_i),
    .ts_ready_o (s_axis_tready_o),
    .ts_i       (s_axis_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue decouples front stalls from output back-pressure
  jshm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .empty_o (empty)
  );

  // Back: health tests, failure counter, registered result
  jshm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_user_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
